@@ hdl/kc_pkg.sv @@
// Shared types and constants of the Kirsch compass edge detector.
package kc_pkg;

    localparam int KC_PIX_W  = 8;
    localparam int KC_ROW_W  = 12;
    localparam int KC_COL_W  = 10;
    localparam int KC_STR_W  = 12;
    localparam int KC_THR_W  = 10;
    localparam int KC_CFGW   = 12;
    localparam int KC_IDXW   = 2;
    localparam int KC_SUM_W  = 14;
    localparam int KC_SQ_W   = 24;
    localparam int KC_WIN_N  = 9;

    localparam int KC_QDEPTH = 4;
    localparam int KC_QAW    = $clog2(KC_QDEPTH);
    localparam int KC_QLW    = $clog2(KC_QDEPTH + 1);

    // register indexes of the configuration port
    localparam logic [KC_IDXW-1:0] KC_REG_WIDTH  = 2'd0;
    localparam logic [KC_IDXW-1:0] KC_REG_HEIGHT = 2'd1;
    localparam logic [KC_IDXW-1:0] KC_REG_THRESH = 2'd2;

    localparam logic [KC_ROW_W-1:0] KC_RST_HEIGHT = 12'd512;
    localparam logic [KC_THR_W-1:0] KC_RST_THRESH = 10'd125;

    localparam logic [KC_PIX_W-1:0] KC_PIX_EDGE = 8'd0;
    localparam logic [KC_PIX_W-1:0] KC_PIX_NONE = 8'd255;

    // ring of the window clockwise from top-left: NW N NE E SE S SW W
    localparam int KC_RING [8] = '{0, 1, 2, 5, 8, 7, 6, 3};

    typedef logic [KC_WIN_N-1:0][KC_PIX_W-1:0] t_kc_win;

    typedef struct packed {
        logic [KC_ROW_W-1:0] row;
        logic [KC_COL_W-1:0] col;
        logic                border;
        logic                last;
    } t_kc_meta;

    typedef struct packed {
        t_kc_win  win;
        t_kc_meta meta;
    } t_kc_item;

endpackage

@@ hdl/kc_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
module kc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/kc_front.sv @@
// Front end: raster counters, line stores, 3x3 window and centre classification.
module kc_front import kc_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    localparam int AW  = $clog2(MAX_WIDTH),
    localparam int WW  = $clog2(MAX_WIDTH + 1),
    localparam int CXW = (AW > KC_COL_W) ? AW : KC_COL_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KC_PIX_W-1:0] i_pixel_in,
    input  logic [WW-1:0]       i_eff_w,
    input  logic [KC_ROW_W-1:0] i_eff_h,
    input  logic                i_restart,
    input  logic [KC_QLW-1:0]   i_q_level,
    output logic                o_push,
    output t_kc_item            o_item
);

    logic                 accept;
    logic [KC_ROW_W-1:0]  r_row, n_row;
    logic [AW-1:0]        r_col, n_col;
    logic [KC_ROW_W:0]    row_p1;
    logic [WW-1:0]        col_p1;
    logic [CXW-1:0]       col_m1;
    logic                 col_wrap, row_wrap;

    logic                 r_s1_valid;
    logic                 r_s1_produce;
    logic [KC_PIX_W-1:0]  r_s1_px;
    logic [AW-1:0]        r_s1_addr;
    t_kc_meta             r_s1_meta;
    t_kc_meta             n_meta;

    logic [2*KC_PIX_W-1:0] ls_rdata;
    t_kc_win              r_win, n_win;

    assign accept   = i_valid && o_ready;
    assign o_ready  = ({1'b0, i_q_level} + (KC_QLW + 1)'(r_s1_valid))
                      < (KC_QLW + 1)'(KC_QDEPTH);

    assign row_p1   = {1'b0, r_row} + 1'b1;
    assign col_p1   = WW'(r_col) + 1'b1;
    assign col_m1   = CXW'(r_col) - 1'b1;
    assign col_wrap = col_p1 >= i_eff_w;
    assign row_wrap = row_p1 >= {1'b0, i_eff_h};

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : row_p1[KC_ROW_W-1:0];
        end else begin
            n_col = col_p1[AW-1:0];
        end
    end

    // a centre (r-1,c-1) is complete once pixel (r,c) arrives
    always_comb begin
        n_meta.row    = r_row - 1'b1;
        n_meta.col    = col_m1[KC_COL_W-1:0];
        n_meta.border = (r_row < KC_ROW_W'(3)) || (r_col < AW'(3)) ||
                        (row_p1 >= {1'b0, i_eff_h}) || (col_p1 >= i_eff_w);
        n_meta.last   = (row_p1 == {1'b0, i_eff_h}) && (col_p1 == i_eff_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_row <= '0;
                r_col <= '0;
            end else if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_produce <= (r_row >= KC_ROW_W'(2)) && (r_col >= AW'(2));
            r_s1_px      <= i_pixel_in;
            r_s1_addr    <= r_col;
            r_s1_meta    <= n_meta;
        end
    end

    // upper store in the high byte, lower store in the low byte;
    // the rotate write lands in the cycle after the read of the same column
    kc_ram #(
        .WIDTH (2 * KC_PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata ({ls_rdata[KC_PIX_W-1:0], r_s1_px}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ls_rdata)
    );

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[2] = ls_rdata[2*KC_PIX_W-1:KC_PIX_W];
        n_win[5] = ls_rdata[KC_PIX_W-1:0];
        n_win[8] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    assign o_push      = r_s1_valid && r_s1_produce;
    assign o_item.win  = n_win;
    assign o_item.meta = r_s1_meta;

endmodule

@@ hdl/kc_queue.sv @@
// Small register FIFO between front end and compass back end.
module kc_queue import kc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_kc_item          i_item,
    input  logic              i_pop,
    output t_kc_item          o_head,
    output logic              o_avail,
    output logic [KC_QLW-1:0] o_level
);

    t_kc_item          r_mem [KC_QDEPTH];
    logic [KC_QAW-1:0] r_wp, r_rp;
    logic [KC_QLW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + KC_QLW'(i_push) - KC_QLW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_avail = r_count != '0;
    assign o_level = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count < KC_QLW'(KC_QDEPTH))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue pop while empty");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a push");

endmodule

@@ hdl/kc_back.sv @@
// Back end: eight compass sums, maximum, threshold test and output register.
module kc_back import kc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_kc_item            i_head,
    input  logic                i_avail,
    output logic                o_pop,
    input  logic [KC_THR_W-1:0] i_thresh,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [KC_ROW_W-1:0] o_centre_row,
    output logic [KC_COL_W-1:0] o_centre_col,
    output logic [KC_PIX_W-1:0] o_pixel_out,
    output logic [KC_STR_W-1:0] o_strength,
    output logic                o_frame_done
);

    logic en;

    logic [KC_PIX_W-1:0]        ring [8];
    logic [KC_PIX_W+2:0]        total;
    logic [KC_SUM_W-2:0]        tot3;
    logic [KC_PIX_W+1:0]        three [8];
    logic signed [KC_SUM_W-1:0] sums [8];

    logic                       r_b1_valid;
    logic signed [KC_SUM_W-1:0] r_b1_sums [8];
    t_kc_meta                   r_b1_meta;

    logic signed [KC_SUM_W-1:0] l1 [4];
    logic signed [KC_SUM_W-1:0] l2 [2];
    logic signed [KC_SUM_W-1:0] best;

    logic                       r_b2_valid;
    logic [KC_STR_W-1:0]        r_b2_str;
    t_kc_meta                   r_b2_meta;

    logic                       r_b3_valid;
    logic [KC_STR_W-1:0]        r_b3_str;
    logic [KC_SQ_W-1:0]         r_b3_sq;
    t_kc_meta                   r_b3_meta;

    logic [2*KC_THR_W-1:0]      r_tsq;
    logic [KC_SQ_W-1:0]         r_lim;

    logic                       r_out_valid;
    logic                       r_out_border;
    logic [KC_ROW_W-1:0]        r_out_row;
    logic [KC_COL_W-1:0]        r_out_col;
    logic [KC_PIX_W-1:0]        r_out_pix;
    logic [KC_STR_W-1:0]        r_out_str;
    logic                       r_out_last;

    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && i_avail;

    // sum = 5*three - 3*(other five) = 8*three - 3*total
    always_comb begin
        total = '0;
        for (int k = 0; k < 8; k++) begin
            ring[k] = i_head.win[KC_RING[k]];
            total   = total + (KC_PIX_W + 3)'(ring[k]);
        end
        tot3 = (KC_SUM_W - 1)'(total) + (KC_SUM_W - 1)'({total, 1'b0});
        for (int k = 0; k < 8; k++) begin
            three[k] = (KC_PIX_W + 2)'(ring[k]) + (KC_PIX_W + 2)'(ring[(k + 1) % 8])
                     + (KC_PIX_W + 2)'(ring[(k + 2) % 8]);
            sums[k]  = $signed({1'b0, three[k], 3'b000}) - $signed({1'b0, tot3});
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            l1[k] = (r_b1_sums[2*k] > r_b1_sums[2*k+1]) ? r_b1_sums[2*k] : r_b1_sums[2*k+1];
        end
        for (int k = 0; k < 2; k++) begin
            l2[k] = (l1[2*k] > l1[2*k+1]) ? l1[2*k] : l1[2*k+1];
        end
        best = (l2[0] > l2[1]) ? l2[0] : l2[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_b1_valid  <= o_pop;
            r_b2_valid  <= r_b1_valid;
            r_b3_valid  <= r_b2_valid;
            r_out_valid <= r_b3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_sums <= sums;
            r_b1_meta <= i_head.meta;

            r_b2_str  <= best[KC_SUM_W-1] ? '0 : best[KC_STR_W-1:0];
            r_b2_meta <= r_b1_meta;

            r_b3_str  <= r_b2_str;
            r_b3_sq   <= r_b2_str * r_b2_str;
            r_b3_meta <= r_b2_meta;

            if (r_b3_valid) begin
                r_out_border <= r_b3_meta.border;
                r_out_row    <= r_b3_meta.row;
                r_out_col    <= r_b3_meta.col;
                r_out_last   <= r_b3_meta.last;
                r_out_str    <= r_b3_meta.border ? '0 : r_b3_str;
                r_out_pix    <= (!r_b3_meta.border && (r_b3_sq > r_lim)) ?
                                KC_PIX_EDGE : KC_PIX_NONE;
            end
        end
    end

    // 15*t*t, registered through r_tsq into r_lim after a threshold write
    always_ff @(posedge i_clk) begin
        r_tsq <= i_thresh * i_thresh;
        r_lim <= {r_tsq, 4'b0000} - KC_SQ_W'(r_tsq);
    end

    assign o_valid      = r_out_valid;
    assign o_centre_row = r_out_row;
    assign o_centre_col = r_out_col;
    assign o_pixel_out  = r_out_pix;
    assign o_strength   = r_out_str;
    assign o_frame_done = r_out_last;

    a_border_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_border) |-> (r_out_pix == KC_PIX_NONE && r_out_str == '0))
        else $error("border centre reported as edge");

    a_edge_needs_strength: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_pix == KC_PIX_EDGE) |-> r_out_str != '0)
        else $error("edge with zero strength");

endmodule

@@ hdl/kirsch_compass_edge_detector_unit.sv @@
// Top level of the streaming 3x3 Kirsch compass edge detector.
// Usage:
//   Pixels enter in raster order on i_valid/o_ready with i_pixel_in. Each
//   transaction whose pixel completes a 3x3 window (row >= 2, col >= 2) gives
//   one result transaction on o_valid/i_ready: centre position, edge flag in
//   o_pixel_out (0 edge, 255 none or border), strength, and o_frame_done on
//   the last centre of the frame.
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while
//   the block is idle; writing width or height restarts the frame position.
// Timing:
//   One pixel per cycle while o_ready holds, set by the line store RAM which
//   takes one read and one write each cycle. The result of a completed window
//   passes the front register, queue, stages b1 to b3 and output register.
// Reset:
//   Position counters, queue and pipeline valids clear; registers return to
//   width 512, height 512, threshold 125. Line stores are not swept: their
//   stale entries reach only the windows of the first two rows, which give no result.
// Stall:
//   A stalled receiver freezes the back end; a 4-entry queue absorbs results
//   and o_ready falls when the queue and the pixel in flight would fill it.
module kirsch_compass_edge_detector_unit import kc_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KC_PIX_W-1:0] i_pixel_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [KC_ROW_W-1:0] o_centre_row,
    output logic [KC_COL_W-1:0] o_centre_col,
    output logic [KC_PIX_W-1:0] o_pixel_out,
    output logic [KC_STR_W-1:0] o_strength,
    output logic                o_frame_done,
    input  logic                i_cfg_we,
    input  logic [KC_IDXW-1:0]  i_cfg_index,
    input  logic [KC_CFGW-1:0]  i_cfg_data
);

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CW   = (WW > 11) ? WW : 11;
    localparam int RSTW = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;

    logic [WW-1:0]        r_eff_w;
    logic [KC_ROW_W-1:0]  r_eff_h;
    logic [KC_THR_W-1:0]  r_thresh;
    logic [10:0]          wr_w;
    logic [WW-1:0]        n_eff_w;
    logic                 restart;

    logic                 q_push, q_pop, q_avail;
    t_kc_item             q_in, q_head;
    logic [KC_QLW-1:0]    q_level;

    assign wr_w = i_cfg_data[10:0];

    always_comb begin
        priority if (wr_w == '0) begin
            n_eff_w = WW'(1);
        end else if (CW'(wr_w) > CW'(MAX_WIDTH)) begin
            n_eff_w = WW'(MAX_WIDTH);
        end else begin
            n_eff_w = WW'(wr_w);
        end
    end

    assign restart = i_cfg_we &&
                     (i_cfg_index == KC_REG_WIDTH || i_cfg_index == KC_REG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w  <= WW'(RSTW);
            r_eff_h  <= KC_RST_HEIGHT;
            r_thresh <= KC_RST_THRESH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                KC_REG_WIDTH:  r_eff_w  <= n_eff_w;
                KC_REG_HEIGHT: r_eff_h  <= (i_cfg_data == '0) ? KC_ROW_W'(1) : i_cfg_data;
                KC_REG_THRESH: r_thresh <= i_cfg_data[KC_THR_W-1:0];
                default: ;
            endcase
        end
    end

    kc_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel_in (i_pixel_in),
        .i_eff_w    (r_eff_w),
        .i_eff_h    (r_eff_h),
        .i_restart  (restart),
        .i_q_level  (q_level),
        .o_push     (q_push),
        .o_item     (q_in)
    );

    kc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_avail (q_avail),
        .o_level (q_level)
    );

    kc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_avail      (q_avail),
        .o_pop        (q_pop),
        .i_thresh     (r_thresh),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_centre_row (o_centre_row),
        .o_centre_col (o_centre_col),
        .o_pixel_out  (o_pixel_out),
        .o_strength   (o_strength),
        .o_frame_done (o_frame_done)
    );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the streaming 3x3 Kirsch compass edge detector.
`timescale 1ns / 1ps

module testbench;
    import kc_pkg::*;

    localparam logic [KC_IDXW-1:0] REG_SPARE = 2'd3;
    localparam int LINE_DEPTH    = 1024;
    localparam int LATENCY_PAUSE = 12;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 100;

    typedef enum int {PIX_NOISE, PIX_BINARY, PIX_STRIPES, PIX_FLAT, PIX_BAR} t_pix_style;

    typedef struct packed {
        logic [KC_ROW_W-1:0] row;
        logic [KC_COL_W-1:0] col;
        logic [KC_PIX_W-1:0] pix;
        logic [KC_STR_W-1:0] strength;
        logic                done;
    } t_edge_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [KC_PIX_W-1:0] i_pixel_in;
    logic                o_valid;
    logic                i_ready;
    logic [KC_ROW_W-1:0] o_centre_row;
    logic [KC_COL_W-1:0] o_centre_col;
    logic [KC_PIX_W-1:0] o_pixel_out;
    logic [KC_STR_W-1:0] o_strength;
    logic                o_frame_done;
    logic                i_cfg_we;
    logic [KC_IDXW-1:0]  i_cfg_index;
    logic [KC_CFGW-1:0]  i_cfg_data;

    // predictor state
    logic [KC_PIX_W-1:0] upper_line [LINE_DEPTH];
    logic [KC_PIX_W-1:0] lower_line [LINE_DEPTH];
    logic [KC_PIX_W-1:0] win_px [KC_WIN_N];
    int                  row_pos;
    int                  col_pos;
    logic [10:0]         cfg_width_r;
    logic [11:0]         cfg_height_r;
    logic [KC_THR_W-1:0] cfg_thresh_r;

    t_edge_result pending_centres [$];
    int           error_count;
    int           idle_cycles;
    int           ready_holdoff;
    bit           no_idle;

    kirsch_compass_edge_detector_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_in   (i_pixel_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_centre_row (o_centre_row),
        .o_centre_col (o_centre_col),
        .o_pixel_out  (o_pixel_out),
        .o_strength   (o_strength),
        .o_frame_done (o_frame_done),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int active_width();
        if (cfg_width_r == 0) return 1;
        if (cfg_width_r > LINE_DEPTH) return LINE_DEPTH;
        return int'(cfg_width_r);
    endfunction

    function automatic int active_height();
        return (cfg_height_r == 0) ? 1 : int'(cfg_height_r);
    endfunction

    function automatic void clear_predictor();
        int k;
        for (k = 0; k < LINE_DEPTH; k++) begin
            upper_line[k] = '0;
            lower_line[k] = '0;
        end
        for (k = 0; k < KC_WIN_N; k++) win_px[k] = '0;
        row_pos      = 0;
        col_pos      = 0;
        cfg_width_r  = 11'd512;
        cfg_height_r = KC_RST_HEIGHT;
        cfg_thresh_r = KC_RST_THRESH;
    endfunction

    // Advances the window by one pixel and queues the centre result it completes.
    function automatic void predict_kirsch(input logic [KC_PIX_W-1:0] px);
        int w, h, r, c, cr, cc, k, total, best, three, s;
        int ring [8];
        logic border;
        t_edge_result res;
        w = active_width();
        h = active_height();
        r = row_pos;
        c = col_pos;
        if (c >= w) c = w - 1;
        win_px[0] = win_px[1];
        win_px[1] = win_px[2];
        win_px[3] = win_px[4];
        win_px[4] = win_px[5];
        win_px[6] = win_px[7];
        win_px[7] = win_px[8];
        win_px[2] = upper_line[c];
        win_px[5] = lower_line[c];
        win_px[8] = px;
        upper_line[c] = lower_line[c];
        lower_line[c] = px;
        if (r >= 2 && c >= 2) begin
            cr = r - 1;
            cc = c - 1;
            border = (cr < 2) || (cc < 2) || (cr + 2 >= h) || (cc + 2 >= w);
            res.row      = KC_ROW_W'(cr);
            res.col      = KC_COL_W'(cc);
            res.pix      = KC_PIX_NONE;
            res.strength = '0;
            if (!border) begin
                total = 0;
                best  = 0;
                for (k = 0; k < 8; k++) begin
                    ring[k] = int'(win_px[KC_RING[k]]);
                    total += ring[k];
                end
                // weight 5 on three neighbors, -3 on the rest: 8*three - 3*total
                for (k = 0; k < 8; k++) begin
                    three = ring[k] + ring[(k + 1) % 8] + ring[(k + 2) % 8];
                    s = 8 * three - 3 * total;
                    if (s > best) best = s;
                end
                res.strength = KC_STR_W'(best);
                if (best * best > 15 * int'(cfg_thresh_r) * int'(cfg_thresh_r))
                    res.pix = KC_PIX_EDGE;
            end
            res.done = (r + 1 == h) && (c + 1 == w);
            pending_centres.push_back(res);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endfunction

    function automatic logic [KC_PIX_W-1:0] gen_pixel(input t_pix_style style, input int r,
                                                      input int c);
        case (style)
            PIX_BINARY:  return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            PIX_STRIPES: return (((c + r) % 4) < 2) ? 8'd255 : 8'd0;
            PIX_FLAT:    return 8'd77;
            PIX_BAR:     return (r == 1) ? 8'd255 : 8'd0;
            default:     return KC_PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_edge_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_centres.size() == 0) begin
                $error("unexpected result transaction: row %0d col %0d",
                       o_centre_row, o_centre_col);
                error_count++;
            end else begin
                want = pending_centres.pop_front();
                compare_field("centre_row", 16'(want.row), 16'(o_centre_row));
                compare_field("centre_col", 16'(want.col), 16'(o_centre_col));
                compare_field("pixel_out", 16'(want.pix), 16'(o_pixel_out));
                compare_field("strength", 16'(want.strength), 16'(o_strength));
                compare_field("frame_done", 16'(want.done), 16'(o_frame_done));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Result side: random stalls, plus long hold-offs on request.
    initial begin : result_sink
        int gap;
        i_ready <= 1'b0;
        forever begin
            if (ready_holdoff > 0) begin
                gap = ready_holdoff;
                ready_holdoff = 0;
                repeat (gap) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
            end
            gap = no_idle ? 0 : $urandom_range(0, 11);
            repeat (gap) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            forever begin
                @(posedge i_clk);
                if (o_valid || ready_holdoff > 0) break;
            end
        end
    end

    task automatic send_pixel(input logic [KC_PIX_W-1:0] px);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_pixel_in <= px;
        do @(posedge i_clk); while (!o_ready);
        predict_kirsch(px);
    endtask

    task automatic send_run(input int run_w, input int count, input t_pix_style style);
        int i;
        for (i = 0; i < count; i++) send_pixel(gen_pixel(style, i / run_w, i % run_w));
    endtask

    // Drop valid, wait for every queued result, then let the pipeline empty.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_centres.size() != 0) @(posedge i_clk);
        repeat (LATENCY_PAUSE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [KC_IDXW-1:0] idx, input logic [KC_CFGW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            KC_REG_WIDTH: begin
                cfg_width_r = data[10:0];
                row_pos = 0;
                col_pos = 0;
            end
            KC_REG_HEIGHT: begin
                cfg_height_r = data[11:0];
                row_pos = 0;
                col_pos = 0;
            end
            KC_REG_THRESH: cfg_thresh_r = data[KC_THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [KC_CFGW-1:0] w, input logic [KC_CFGW-1:0] h,
                             input logic [KC_CFGW-1:0] thr);
        settle();
        write_reg(KC_REG_WIDTH, w);
        write_reg(KC_REG_HEIGHT, h);
        write_reg(KC_REG_THRESH, thr);
    endtask

    // Bright top bar gives the largest response; 987/988 straddle the decision for it.
    task automatic test_compass_extremes();
        set_frame(5, 5, 125);
        send_run(5, 25, PIX_BAR);
        set_frame(5, 5, 987);
        send_run(5, 25, PIX_BAR);
        set_frame(5, 5, 988);
        // unused index must not touch the threshold
        write_reg(REG_SPARE, 12'h000);
        send_run(5, 25, PIX_BAR);
    endtask

    task automatic test_threshold_extremes();
        set_frame(6, 6, 0);
        send_run(6, 36, PIX_NOISE);
        send_run(6, 36, PIX_FLAT);
        set_frame(6, 6, 1023);
        send_run(6, 36, PIX_BINARY);
        set_frame(7, 5, 60);
        send_run(7, 35, PIX_STRIPES);
    endtask

    task automatic test_small_frames();
        set_frame(12'h800, 5, 100);    // masked to width 0, used as 1
        send_run(1, 10, PIX_NOISE);
        set_frame(2, 6, 100);
        send_run(2, 12, PIX_NOISE);
        set_frame(6, 0, 100);          // height 0 used as 1
        send_run(6, 12, PIX_NOISE);
        set_frame(6, 2, 100);
        send_run(6, 24, PIX_NOISE);
        set_frame(3, 3, 100);          // single border centre ends the frame
        send_run(3, 18, PIX_NOISE);
    endtask

    task automatic test_frame_restart();
        set_frame(7, 6, 90);
        send_run(7, 20, PIX_NOISE);
        settle();
        write_reg(KC_REG_HEIGHT, 6);
        send_run(7, 84, PIX_BINARY);
        settle();
        write_reg(KC_REG_WIDTH, 9);
        send_run(9, 54, PIX_NOISE);
    endtask

    task automatic test_backpressure();
        set_frame(8, 8, 150);
        no_idle = 1'b1;
        ready_holdoff = 200;
        send_run(8, 64, PIX_NOISE);
        no_idle = 1'b0;
        set_frame(8, 6, 150);
        send_run(8, 24, PIX_NOISE);
        settle();                      // sender waits mid-frame for all results
        send_run(8, 24, PIX_BINARY);
    endtask

    task automatic test_random_frames();
        int sent, w, h, thr, count;
        t_pix_style style;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(3, 12);
            h = $urandom_range(3, 9);
            case ($urandom_range(0, 5))
                0:       thr = 0;
                1:       thr = 1023;
                default: thr = $urandom_range(20, 400);
            endcase
            style = t_pix_style'($urandom_range(0, 3));
            set_frame(KC_CFGW'(w), KC_CFGW'(h), KC_CFGW'(thr));
            no_idle = ($urandom_range(0, 4) == 0);
            // mostly whole frames, sometimes a frame cut short by a restart
            if ($urandom_range(0, 7) == 0)
                count = $urandom_range(1, w * h - 1);
            else
                count = w * h * $urandom_range(1, 2);
            if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
            send_run(w, count, style);
            sent += count;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_pixel_in    <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= KC_REG_WIDTH;
        i_cfg_data    <= '0;
        error_count   = 0;
        idle_cycles   = 0;
        ready_holdoff = 0;
        no_idle       = 1'b0;
        clear_predictor();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_compass_extremes();
        test_threshold_extremes();
        test_small_frames();
        test_frame_restart();
        test_backpressure();
        test_random_frames();

        settle();
        if (pending_centres.size() != 0) begin
            $error("%0d expected results never arrived", pending_centres.size());
            error_count++;
        end
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
hdl/kc_pkg.sv
hdl/kc_ram.sv
hdl/kc_front.sv
hdl/kc_queue.sv
hdl/kc_back.sv
hdl/kirsch_compass_edge_detector_unit.sv
test/testbench.sv
